// ===== src/rpnse_pkg.sv =====
// ----------------------------------------------------------------------------
// rpnse_pkg
// shared widths, op codes and status codes of the rpn stack evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpnse_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int CODE_W      = 3;
    localparam int DEPTH_W     = 5;

    typedef logic [CODE_W-1:0]      t_code;
    typedef logic signed [DATA_W-1:0] t_data;

    // op codes
    localparam t_code OP_PUSH   = 3'd0;
    localparam t_code OP_ADD    = 3'd1;
    localparam t_code OP_SUB    = 3'd2;
    localparam t_code OP_MUL    = 3'd3;
    localparam t_code OP_DIV    = 3'd4;
    localparam t_code OP_FINISH = 3'd5;

    // status codes
    localparam t_code ST_OK       = 3'd0;
    localparam t_code ST_OVERFLOW = 3'd1;
    localparam t_code ST_FEW      = 3'd2;
    localparam t_code ST_DIV      = 3'd3;
    localparam t_code ST_DEPTH    = 3'd4;
    localparam t_code ST_IGNORED  = 3'd5;

    localparam t_data SAT_MAX = 32'sh7fff_ffff;
    localparam t_data SAT_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

// ===== src/rpn_stack_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_top
// reverse polish evaluator on a bounded stack of signed q16.16 values
// ----------------------------------------------------------------------------
// usage:
//   a beat is taken at a rising edge with start high and busy low; i_op picks
//   push, add, subtract, multiply, divide or finish, i_operand_value is the
//   pushed number. every beat gives exactly one result beat on o_status,
//   o_top_value and o_stack_depth, marked by o_valid for one cycle.
//   push, finish, divide and every error or ignored beat give their result
//   straight from S_IDLE; add and subtract pass through S_EXEC, multiply
//   through S_MUL. busy is low again in the cycle o_valid is high, so push
//   beats go at one per cycle; an operator holds off the next beat until
//   its result. the wait is set by the registered read of the second entry
//   from the stack memory and the registered multiplier.
//   the top of stack sits in a register; the memory holds every entry.
//   reset clears depth and held error; memory contents need no clearing.
//   there is no back-pressure: results must be taken when o_valid is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpn_stack_evaluator_top #(
    parameter int STACK_DEPTH = rpnse_pkg::STACK_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [rpnse_pkg::CODE_W-1:0]   i_op,
    input  wire logic signed [rpnse_pkg::DATA_W-1:0] i_operand_value,
    output logic                                o_valid,
    output logic [rpnse_pkg::CODE_W-1:0]        o_status,
    output logic signed [rpnse_pkg::DATA_W-1:0] o_top_value,
    output logic [rpnse_pkg::DEPTH_W-1:0]       o_stack_depth
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_MUL  = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_count, n_count;
    rpnse_pkg::t_code       r_err, n_err;
    rpnse_pkg::t_data       r_top, n_top;
    logic                   r_sub, n_sub;
    logic                   r_valid, n_valid;
    rpnse_pkg::t_code       r_status, n_status;
    rpnse_pkg::t_data       r_out_top, n_out_top;
    logic [CW-1:0]          r_out_depth, n_out_depth;

    logic                   w_accept;
    logic                   w_we;
    logic [AW-1:0]          w_waddr;
    rpnse_pkg::t_data       w_wdata;
    logic                   w_re;
    logic [AW-1:0]          w_raddr;
    rpnse_pkg::t_data       w_rdata;
    rpnse_pkg::t_data       w_addsub;
    rpnse_pkg::t_data       w_mul;
    logic [CW-1:0]          w_cnt_m1;
    logic [CW-1:0]          w_cnt_m2;
    rpnse_pkg::t_data       w_cur_top;

    rpnse_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    rpnse_alu u_alu (
        .i_clk    (i_clk),
        .i_sub    (r_sub),
        .i_a      (w_rdata),
        .i_b      (r_top),
        .o_addsub (w_addsub),
        .o_mul    (w_mul)
    );

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_cnt_m1 = r_count - CW'(1);
    assign w_cnt_m2 = r_count - CW'(2);
    assign w_cur_top = (r_count == '0) ? '0 : r_top;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_err       = r_err;
        n_top       = r_top;
        n_sub       = r_sub;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_out_top   = r_out_top;
        n_out_depth = r_out_depth;
        w_we        = 1'b0;
        w_waddr     = r_count[AW-1:0];
        w_wdata     = i_operand_value;
        w_re        = 1'b0;
        w_raddr     = w_cnt_m2[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status    = rpnse_pkg::ST_OK;
                    n_out_top   = w_cur_top;
                    n_out_depth = r_count;
                    n_valid     = 1'b1;
                    if (i_op == rpnse_pkg::OP_FINISH) begin
                        n_out_top   = '0;
                        n_out_depth = '0;
                        if (r_err != rpnse_pkg::ST_OK) begin
                            n_status = r_err;
                        end else if (r_count != CW'(1)) begin
                            n_status = rpnse_pkg::ST_DEPTH;
                        end else begin
                            n_out_top = r_top;
                        end
                        n_count = '0;
                        n_err   = rpnse_pkg::ST_OK;
                    end else if (r_err != rpnse_pkg::ST_OK) begin
                        n_status = rpnse_pkg::ST_IGNORED;
                    end else begin
                        case (i_op)
                            rpnse_pkg::OP_PUSH: begin
                                if (r_count >= CW'(STACK_DEPTH)) begin
                                    n_status = rpnse_pkg::ST_OVERFLOW;
                                    n_err    = rpnse_pkg::ST_OVERFLOW;
                                end else begin
                                    w_we        = 1'b1;
                                    n_count     = r_count + CW'(1);
                                    n_top       = i_operand_value;
                                    n_out_top   = i_operand_value;
                                    n_out_depth = r_count + CW'(1);
                                end
                            end
                            rpnse_pkg::OP_ADD, rpnse_pkg::OP_SUB, rpnse_pkg::OP_MUL,
                            rpnse_pkg::OP_DIV: begin
                                if (r_count < CW'(2)) begin
                                    n_status = rpnse_pkg::ST_FEW;
                                    n_err    = rpnse_pkg::ST_FEW;
                                end else if (i_op == rpnse_pkg::OP_DIV) begin
                                    n_status = rpnse_pkg::ST_DIV;
                                    n_err    = rpnse_pkg::ST_DIV;
                                end else begin
                                    // fetch the second entry, result comes later
                                    // r_sub also marks the first multiply cycle
                                    w_re    = 1'b1;
                                    n_valid = 1'b0;
                                    n_sub   = (i_op == rpnse_pkg::OP_SUB) ||
                                              (i_op == rpnse_pkg::OP_MUL);
                                    n_state = (i_op == rpnse_pkg::OP_MUL) ? S_MUL : S_EXEC;
                                end
                            end
                            default: begin
                                n_status = rpnse_pkg::ST_IGNORED;
                            end
                        endcase
                    end
                end
            end
            S_EXEC, S_MUL: begin
                w_wdata = (r_state == S_MUL) ? w_mul : w_addsub;
                if (r_state == S_MUL && r_sub) begin
                    // first multiply cycle: product is being registered
                    n_sub = 1'b0;
                end else begin
                    w_we        = 1'b1;
                    w_waddr     = w_cnt_m2[AW-1:0];
                    n_top       = w_wdata;
                    n_count     = w_cnt_m1;
                    n_valid     = 1'b1;
                    n_status    = rpnse_pkg::ST_OK;
                    n_out_top   = w_wdata;
                    n_out_depth = w_cnt_m1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_err   <= rpnse_pkg::ST_OK;
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_err   <= n_err;
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top       <= n_top;
        r_status    <= n_status;
        r_out_top   <= n_out_top;
        r_out_depth <= n_out_depth;
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_top_value   = r_out_top;
    assign o_stack_depth = rpnse_pkg::DEPTH_W'(r_out_depth);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_op == rpnse_pkg::OP_FINISH) |=> (o_valid && o_stack_depth == '0))
        else $error("finish beat without empty-stack result");

    a_no_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC || r_state == S_MUL) |-> !o_valid)
        else $error("result strobe while an operator is in flight");

    a_err_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != rpnse_pkg::ST_OK) |-> (r_state == S_IDLE))
        else $error("operator in flight with an error held");
`endif

endmodule

`default_nettype wire

// ===== src/rpnse_stack_mem.sv =====
// ----------------------------------------------------------------------------
// rpnse_stack_mem
// stack storage: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpnse_stack_mem #(
    parameter int DEPTH = rpnse_pkg::STACK_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [AW-1:0]       i_waddr,
    input  wire rpnse_pkg::t_data    i_wdata,
    input  wire logic                i_re,
    input  wire logic [AW-1:0]       i_raddr,
    output rpnse_pkg::t_data         o_rdata
);

    rpnse_pkg::t_data r_mem [DEPTH];
    rpnse_pkg::t_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/rpnse_alu.sv =====
// ----------------------------------------------------------------------------
// rpnse_alu
// saturating add / subtract and registered q16.16 multiply
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpnse_alu (
    input  wire logic             i_clk,
    input  wire logic             i_sub,
    input  wire rpnse_pkg::t_data i_a,
    input  wire rpnse_pkg::t_data i_b,
    output rpnse_pkg::t_data      o_addsub,
    output rpnse_pkg::t_data      o_mul
);

    logic signed [rpnse_pkg::DATA_W:0]     w_sum;
    logic signed [2*rpnse_pkg::DATA_W-1:0] r_prod;
    logic                                  w_fits;

    always_comb begin
        if (i_sub) begin
            w_sum = {i_a[rpnse_pkg::DATA_W-1], i_a} - {i_b[rpnse_pkg::DATA_W-1], i_b};
        end else begin
            w_sum = {i_a[rpnse_pkg::DATA_W-1], i_a} + {i_b[rpnse_pkg::DATA_W-1], i_b};
        end
        if (w_sum[rpnse_pkg::DATA_W] != w_sum[rpnse_pkg::DATA_W-1]) begin
            o_addsub = w_sum[rpnse_pkg::DATA_W] ? rpnse_pkg::SAT_MIN : rpnse_pkg::SAT_MAX;
        end else begin
            o_addsub = w_sum[rpnse_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // floor of product / 2^16 is an arithmetic shift; saturate on bits 63:47
    assign w_fits = (r_prod[63:47] == {17{1'b0}}) || (r_prod[63:47] == {17{1'b1}});

    always_comb begin
        if (w_fits) begin
            o_mul = r_prod[47:16];
        end else begin
            o_mul = r_prod[63] ? rpnse_pkg::SAT_MIN : rpnse_pkg::SAT_MAX;
        end
    end

endmodule

`default_nettype wire
